// File: hdl/tpz_pkg.sv
// ----------------------------------------------------------------------------
// tpz_pkg: shared types and constants of the two-touch pinch/zoom detector
// Request, gesture and register codes, table sizes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tpz_pkg;

	// table and field sizes
	localparam int MAX_POINTS  = 8;
	localparam int COORD_BITS  = 12;
	localparam int SLOT_BITS   = $clog2(MAX_POINTS);
	localparam int CNT_BITS    = $clog2(MAX_POINTS + 1);
	localparam int ID_BITS     = 8;
	localparam int REG_BITS    = 12;
	localparam int IDX_BITS    = 3;
	localparam int SQ_BITS     = 2 * COORD_BITS;
	localparam int DIST_BITS   = 2 * COORD_BITS + 1;
	localparam int PCOUNT_BITS = 4;
	localparam int GEST_BITS   = 2;
	localparam int REQ_BITS    = 3;

	localparam logic [REG_BITS-1:0] THRESH_RESET = REG_BITS'(50);

	typedef enum logic [REQ_BITS-1:0] {
		REQ_DOWN   = 3'd0,
		REQ_MOVE   = 3'd1,
		REQ_UP     = 3'd2,
		REQ_UPDATE = 3'd3,
		REQ_RESET  = 3'd4
	} req_t;

	typedef enum logic [GEST_BITS-1:0] {
		GEST_NONE  = 2'd0,
		GEST_ZOOM  = 2'd1,
		GEST_PINCH = 2'd2
	} gesture_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_AREA_LEFT   = 3'd0,
		REG_AREA_TOP    = 3'd1,
		REG_AREA_RIGHT  = 3'd2,
		REG_AREA_BOTTOM = 3'd3,
		REG_THRESHOLD   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_SQX,
		ST_SQY,
		ST_SQT,
		ST_CMP,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// File: hdl/tpz_sq_unit.sv
// ----------------------------------------------------------------------------
// tpz_sq_unit: shared absolute-difference square unit
// Registers (|a - b|)^2; reused for dx^2, dy^2 and the threshold square.
// ----------------------------------------------------------------------------
`default_nettype none

module tpz_sq_unit (
	input  wire logic                          clk,
	input  wire logic [tpz_pkg::COORD_BITS-1:0] a,
	input  wire logic [tpz_pkg::COORD_BITS-1:0] b,
	output logic      [tpz_pkg::SQ_BITS-1:0]    sq
);

	logic [tpz_pkg::COORD_BITS-1:0] diff;
	logic [tpz_pkg::SQ_BITS-1:0]    diff_ext;
	logic [tpz_pkg::SQ_BITS-1:0]    sq_q;

	// take the magnitude of the difference
	always_comb begin
		if (a > b) begin
			diff = a - b;
		end else begin
			diff = b - a;
		end
		diff_ext = tpz_pkg::SQ_BITS'(diff);
	end

	// square and register
	always_ff @(posedge clk) begin
		sq_q <= diff_ext * diff_ext;
	end

	assign sq = sq_q;

endmodule

`default_nettype wire

// File: hdl/two_touch_pinch_zoom_detector.sv
// An accepted request is scanned one slot per cycle, applied, and for an update
// with two points held squared in SQX, SQY and SQT by the shared square unit
// (used three times) and compared in CMP; FINISH registers the result beat and
// waits out output stall. A new request is taken only when back in IDLE.
// Reset: arst_n clears the table, tracking, last distance and gesture, sets
// the area registers to zero and the threshold to 50.
// ----------------------------------------------------------------------------
// two_touch_pinch_zoom_detector: touch table with pinch/zoom classification
// Holds touch points by id, scans them one slot a cycle under a sequencer and
// compares two-point squared distances through one shared square unit.
// ----------------------------------------------------------------------------
`default_nettype none

module two_touch_pinch_zoom_detector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [tpz_pkg::IDX_BITS-1:0]    cfg_idx,
	input  wire logic [tpz_pkg::REG_BITS-1:0]    cfg_wdata,
	// request channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tpz_pkg::REQ_BITS-1:0]    req_type,
	input  wire logic [tpz_pkg::COORD_BITS-1:0]  pos_x,
	input  wire logic [tpz_pkg::COORD_BITS-1:0]  pos_y,
	input  wire logic [tpz_pkg::ID_BITS-1:0]     touch_id,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [tpz_pkg::GEST_BITS-1:0]   gesture,
	output logic                                gesture_found,
	output logic      [tpz_pkg::PCOUNT_BITS-1:0] point_count,
	output logic                                table_full
);

	localparam int NP = tpz_pkg::MAX_POINTS;
	localparam int SB = tpz_pkg::SLOT_BITS;
	localparam int CB = tpz_pkg::COORD_BITS;
	localparam int KB = tpz_pkg::CNT_BITS;
	localparam logic [SB-1:0] LAST_SLOT = SB'(NP - 1);

	// configuration registers
	logic [tpz_pkg::REG_BITS-1:0] left_q, top_q, right_q, bottom_q, thr_q;

	// touch table: valid bits reset, payload undefined until written
	logic [NP-1:0]                  valid_q;
	logic [tpz_pkg::ID_BITS-1:0]    slot_id_q [NP];
	logic [CB-1:0]                  slot_x_q  [NP];
	logic [CB-1:0]                  slot_y_q  [NP];

	// gesture tracking
	logic [tpz_pkg::DIST_BITS-1:0]  last_q;
	logic                           tracking_q;
	tpz_pkg::gesture_t              gest_q;

	// latched request
	tpz_pkg::req_t                  req_q;
	logic [CB-1:0]                  x_q, y_q;
	logic [tpz_pkg::ID_BITS-1:0]    id_q;

	// scan results
	logic [SB-1:0]                  idx_q;
	logic                           match_q, free_q;
	logic [SB-1:0]                  match_idx_q, free_idx_q;
	logic [KB-1:0]                  cnt_q;
	logic [CB-1:0]                  xa_q, ya_q, xb_q, yb_q;

	// distance arithmetic
	logic [tpz_pkg::DIST_BITS-1:0]  acc_q;
	logic                           dropped_q;

	// output register
	logic                           out_valid_q;
	tpz_pkg::gesture_t              out_gest_q;
	logic [tpz_pkg::PCOUNT_BITS-1:0] out_cnt_q;
	logic                           out_full_q;

	// sequencer
	tpz_pkg::state_t                state_q, state_d;
	logic                           accept;
	logic                           out_free;
	logic                           in_area;
	logic [CB-1:0]                  op_a, op_b;
	logic [tpz_pkg::SQ_BITS-1:0]    sq;
	logic [tpz_pkg::DIST_BITS-1:0]  sq_ext;
	logic [KB-1:0]                  pop;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign sq_ext   = tpz_pkg::DIST_BITS'(sq);

	// inclusive area check on the latched point
	assign in_area = (x_q >= left_q) && (x_q <= right_q) &&
		(y_q >= top_q) && (y_q <= bottom_q);

	// count held points for the result
	always_comb begin
		pop = '0;
		for (int i = 0; i < NP; i++) begin
			pop = pop + KB'(valid_q[i]);
		end
	end

	// shared square unit operand select
	always_comb begin
		case (state_q)
			tpz_pkg::ST_SQX: begin
				op_a = xa_q;
				op_b = xb_q;
			end
			tpz_pkg::ST_SQY: begin
				op_a = ya_q;
				op_b = yb_q;
			end
			default: begin
				op_a = CB'(thr_q);
				op_b = '0;
			end
		endcase
	end

	tpz_sq_unit u_sq (
		.clk (clk),
		.a   (op_a),
		.b   (op_b),
		.sq  (sq)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpz_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			tpz_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = tpz_pkg::ST_SCAN;
				end
			end
			tpz_pkg::ST_SCAN: begin
				if (idx_q == LAST_SLOT) begin
					state_d = tpz_pkg::ST_APPLY;
				end
			end
			tpz_pkg::ST_APPLY: begin
				if (req_q == tpz_pkg::REQ_UPDATE && cnt_q == KB'(2)) begin
					state_d = tpz_pkg::ST_SQX;
				end else begin
					state_d = tpz_pkg::ST_FINISH;
				end
			end
			tpz_pkg::ST_SQX:    state_d = tpz_pkg::ST_SQY;
			tpz_pkg::ST_SQY:    state_d = tpz_pkg::ST_SQT;
			tpz_pkg::ST_SQT:    state_d = tpz_pkg::ST_CMP;
			tpz_pkg::ST_CMP:    state_d = tpz_pkg::ST_FINISH;
			tpz_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = tpz_pkg::ST_IDLE;
				end
			end
			default: state_d = tpz_pkg::ST_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= '0;
			bottom_q <= '0;
			thr_q    <= tpz_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				tpz_pkg::REG_AREA_LEFT:   left_q   <= cfg_wdata;
				tpz_pkg::REG_AREA_TOP:    top_q    <= cfg_wdata;
				tpz_pkg::REG_AREA_RIGHT:  right_q  <= cfg_wdata;
				tpz_pkg::REG_AREA_BOTTOM: bottom_q <= cfg_wdata;
				tpz_pkg::REG_THRESHOLD:   thr_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// latch the request beat
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= tpz_pkg::req_t'(req_type);
			x_q   <= pos_x;
			y_q   <= pos_y;
			id_q  <= touch_id;
		end
	end

	// scan one slot a cycle: first match, first free, first two valid points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			idx_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (state_q == tpz_pkg::ST_SCAN) begin
			idx_q <= idx_q + SB'(1);
			if (valid_q[idx_q]) begin
				cnt_q <= cnt_q + KB'(1);
				if (!match_q && slot_id_q[idx_q] == id_q) begin
					match_q <= 1'b1;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	// scan payload captures
	always_ff @(posedge clk) begin
		if (state_q == tpz_pkg::ST_SCAN) begin
			if (valid_q[idx_q]) begin
				if (!match_q && slot_id_q[idx_q] == id_q) begin
					match_idx_q <= idx_q;
				end
				if (cnt_q == KB'(0)) begin
					xa_q <= slot_x_q[idx_q];
					ya_q <= slot_y_q[idx_q];
				end else if (cnt_q == KB'(1)) begin
					xb_q <= slot_x_q[idx_q];
					yb_q <= slot_y_q[idx_q];
				end
			end else if (!free_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	// table valid bits: set on down, clear all on up and reset requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == tpz_pkg::ST_APPLY) begin
			case (req_q)
				tpz_pkg::REQ_DOWN: begin
					if (in_area && match_q) begin
						valid_q[match_idx_q] <= 1'b1;
					end else if (in_area && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				tpz_pkg::REQ_UP, tpz_pkg::REQ_RESET: valid_q <= '0;
				default: ;
			endcase
		end
	end

	// table payload writes
	always_ff @(posedge clk) begin
		if (state_q == tpz_pkg::ST_APPLY) begin
			case (req_q)
				tpz_pkg::REQ_DOWN: begin
					if (in_area && match_q) begin
						slot_id_q[match_idx_q] <= id_q;
						slot_x_q[match_idx_q]  <= x_q;
						slot_y_q[match_idx_q]  <= y_q;
					end else if (in_area && free_q) begin
						slot_id_q[free_idx_q] <= id_q;
						slot_x_q[free_idx_q]  <= x_q;
						slot_y_q[free_idx_q]  <= y_q;
					end
				end
				tpz_pkg::REQ_MOVE: begin
					if (match_q) begin
						slot_x_q[match_idx_q] <= x_q;
						slot_y_q[match_idx_q] <= y_q;
					end
				end
				default: ;
			endcase
		end
	end

	// flag a down with a new id that found no room
	always_ff @(posedge clk) begin
		if (state_q == tpz_pkg::ST_APPLY) begin
			dropped_q <= (req_q == tpz_pkg::REQ_DOWN) && in_area && !match_q && !free_q;
		end
	end

	// accumulate dx^2 + dy^2 from the shared unit
	always_ff @(posedge clk) begin
		if (state_q == tpz_pkg::ST_SQY) begin
			acc_q <= sq_ext;
		end else if (state_q == tpz_pkg::ST_SQT) begin
			acc_q <= acc_q + sq_ext;
		end
	end

	// gesture tracking: above the threshold latch distance and classify against the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			tracking_q <= 1'b0;
			gest_q     <= tpz_pkg::GEST_NONE;
		end else if (state_q == tpz_pkg::ST_APPLY) begin
			if (req_q == tpz_pkg::REQ_RESET) begin
				gest_q <= tpz_pkg::GEST_NONE;
			end else if (req_q == tpz_pkg::REQ_UPDATE && cnt_q != KB'(2)) begin
				gest_q     <= tpz_pkg::GEST_NONE;
				tracking_q <= 1'b0;
			end
		end else if (state_q == tpz_pkg::ST_CMP && acc_q > sq_ext) begin
			if (tracking_q) begin
				if (acc_q > last_q) begin
					gest_q <= tpz_pkg::GEST_ZOOM;
				end else if (acc_q < last_q) begin
					gest_q <= tpz_pkg::GEST_PINCH;
				end else begin
					gest_q <= tpz_pkg::GEST_NONE;
				end
			end
			last_q     <= acc_q;
			tracking_q <= 1'b1;
		end
	end

	// output valid: load at finish, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tpz_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == tpz_pkg::ST_FINISH && out_free) begin
			out_gest_q <= gest_q;
			out_cnt_q  <= tpz_pkg::PCOUNT_BITS'(pop);
			out_full_q <= dropped_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign gesture       = out_gest_q;
	assign gesture_found = (out_gest_q != tpz_pkg::GEST_NONE);
	assign point_count   = out_cnt_q;
	assign table_full    = out_full_q;

endmodule

`default_nettype wire

// File: hdl/tpz_checker.sv
// ----------------------------------------------------------------------------
// tpz_checker: port-level checks of the pinch/zoom detector
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module tpz_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [tpz_pkg::GEST_BITS-1:0]   gesture,
	input wire logic                           gesture_found,
	input wire logic [tpz_pkg::PCOUNT_BITS-1:0] point_count,
	input wire logic                           table_full
);

	// found flag tracks the gesture code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gesture_found == (gesture != tpz_pkg::GEST_NONE)))
		else $error("gesture_found disagrees with gesture");

	// no more points than the table holds, no unused gesture code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_count <= tpz_pkg::PCOUNT_BITS'(tpz_pkg::MAX_POINTS)) &&
			(gesture != 2'd3))
		else $error("result beat out of range");

	// one request in flight: ready drops after a request beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(gesture) &&
			$stable(point_count) && $stable(table_full))
		else $error("result beat changed while stalled");

endmodule

bind two_touch_pinch_zoom_detector tpz_checker u_tpz_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.gesture       (gesture),
	.gesture_found (gesture_found),
	.point_count   (point_count),
	.table_full    (table_full)
);

`default_nettype wire
